@@ rtl/core/hashed_key_sorted_table_lookup_assert.svh @@
// assertion macros shared by the lookup block
`ifndef HASHED_KEY_SORTED_TABLE_LOOKUP_ASSERT_SVH
`define HASHED_KEY_SORTED_TABLE_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define HKTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// consequent checked in the cycle after the antecedent
`define HKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HKTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define HKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/hktl_pkg.sv @@
`timescale 1ns / 1ps

package hktl_pkg;

	// command codes on the action field
	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_KEY    = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// reflected crc-32 constants
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// ascii case folding
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_FOLD    = 8'd32;

	// one lookup answer
	typedef struct packed {
		logic        found;
		logic [31:0] offset;
		logic [31:0] hash;
	} res_t;

	// fold one key byte to upper case and run it through the crc
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] ch);
		logic [7:0]  c;
		logic [31:0] r;
		c = ch;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			c = c - CASE_FOLD;
		end
		r = crc ^ {24'd0, c};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

@@ rtl/core/hashed_key_sorted_table_lookup.sv @@
`timescale 1ns / 1ps
// Hashed key lookup over TABLES sorted tables of (hash, text offset) entries.
// Command channel: an item transfers at a rising edge with start high and busy
// low. action selects load entry, key byte, search by hash or clear table.
// Load, clear and a key byte without last_char complete at the transfer edge;
// busy stays low and the next item may follow in the next cycle.
// A key byte with last_char, or a search by hash, starts a binary search over
// the entry memory. Each probe is one read of the single read port, and the
// compare of one probe overlaps the address of the next. busy is high during
// the search; loads cannot collide with reads.
// Result channel: done is high for exactly one cycle with found,
// text_offset_out (zero on a miss) and searched_hash; it transfers at the edge
// that ends that cycle. The receiver cannot stall, and a new item may transfer
// in the cycle that done is shown.
// Reset clears the entry counts, the running crc (all ones) and the sequencer;
// the entry memory keeps its contents and is only read below the counts.
module hashed_key_sorted_table_lookup #(
	parameter int TABLES         = 4,
	parameter int KEYS_PER_TABLE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [1:0]  table_select,
	input  logic [7:0]  key_char,
	input  logic        last_char,
	input  logic [31:0] key_hash_in,
	input  logic [31:0] text_offset_in,
	output logic        done,
	output logic        found,
	output logic [31:0] text_offset_out,
	output logic [31:0] searched_hash
);

	localparam int DEPTH = TABLES * KEYS_PER_TABLE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(KEYS_PER_TABLE + 1);
	localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;

	hktl_pkg::action_t act;
	logic              accept;
	logic              in_range;
	logic [TW-1:0]     tsel;
	logic [CW-1:0]     cur_count;
	logic [AW-1:0]     base;
	logic              do_load;
	logic              do_clear;
	logic              do_char;
	logic              launch;
	logic [31:0]       launch_hash;
	logic [31:0]       crc_next;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [63:0]       rd_data;
	hktl_pkg::res_t    res;
	logic [CW-1:0]     count_q [TABLES];

	// command decode
	assign act      = hktl_pkg::action_t'(action);
	assign accept   = start && !busy;
	assign in_range = ({30'd0, table_select} < 32'(TABLES));
	assign tsel     = TW'(table_select);
	assign cur_count = in_range ? count_q[tsel] : '0;
	assign base     = AW'(tsel * KEYS_PER_TABLE);

	assign do_load  = accept && (act == hktl_pkg::ACT_LOAD) && in_range &&
	                  (cur_count < CW'(KEYS_PER_TABLE));
	assign do_clear = accept && (act == hktl_pkg::ACT_CLEAR) && in_range;
	assign do_char  = accept && (act == hktl_pkg::ACT_KEY);
	assign launch   = accept && ((act == hktl_pkg::ACT_SEARCH) ||
	                  ((act == hktl_pkg::ACT_KEY) && last_char));
	assign launch_hash = (act == hktl_pkg::ACT_SEARCH) ? key_hash_in : crc_next;

	// per-table fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLES; i++) begin
				count_q[i] <= '0;
			end
		end else if (do_load) begin
			count_q[tsel] <= cur_count + CW'(1);
		end else if (do_clear) begin
			count_q[tsel] <= '0;
		end
	end

	// running key hash
	hktl_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_en   (do_char),
		.last_char (last_char),
		.key_char  (key_char),
		.crc_next  (crc_next)
	);

	// entry memory, hash in the upper half
	hktl_ram #(
		.WIDTH (64),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_load),
		.wr_addr (base + AW'(cur_count)),
		.wr_data ({key_hash_in, text_offset_in}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// binary search sequencer
	hktl_search #(
		.AW (AW),
		.CW (CW)
	) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.launch       (launch),
		.launch_hash  (launch_hash),
		.launch_base  (base),
		.launch_count (cur_count),
		.busy         (busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.done         (done),
		.res          (res)
	);

	assign found           = res.found;
	assign text_offset_out = res.offset;
	assign searched_hash   = res.hash;

endmodule

@@ rtl/core/hktl_ram.sv @@
`timescale 1ns / 1ps

module hktl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/hktl_crc.sv @@
`timescale 1ns / 1ps

module hktl_crc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_en,
	input  logic        last_char,
	input  logic [7:0]  key_char,
	output logic [31:0] crc_next
);

	logic [31:0] crc_q;

	// crc including the byte now presented
	assign crc_next = hktl_pkg::crc_byte(crc_q, key_char);

	// running crc, restarted after the final byte of a key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= hktl_pkg::CRC_INIT;
		end else if (char_en) begin
			crc_q <= last_char ? hktl_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

@@ rtl/core/hktl_search.sv @@
`timescale 1ns / 1ps
`include "hashed_key_sorted_table_lookup_assert.svh"

module hktl_search #(
	parameter int AW = 10,
	parameter int CW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              launch,
	input  logic [31:0]       launch_hash,
	input  logic [AW-1:0]     launch_base,
	input  logic [CW-1:0]     launch_count,
	output logic              busy,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [63:0]       rd_data,
	output logic              done,
	output hktl_pkg::res_t    res
);

	typedef enum logic {
		S_IDLE,
		S_PROBE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   mid_q;
	logic            pend_q;
	logic [31:0]     hash_q;
	logic [AW-1:0]   base_q;
	logic            done_q;
	hktl_pkg::res_t  res_q;

	logic [31:0]     rd_hash;
	logic            hit;
	logic [CW-1:0]   nlo;
	logic [CW-1:0]   nhi;
	logic [CW-1:0]   nmid;
	logic            go;

	// compare the entry read last cycle and narrow the window
	assign rd_hash = rd_data[63:32];
	assign hit     = pend_q && (rd_hash == hash_q);

	always_comb begin
		nlo = lo_q;
		nhi = hi_q;
		if (pend_q) begin
			if (rd_hash < hash_q) begin
				nlo = mid_q + CW'(1);
			end else begin
				nhi = mid_q;
			end
		end
	end

	assign nmid = nlo + ((nhi - nlo) >> 1);
	assign go   = !hit && (nlo < nhi);

	// next probe is issued in the same cycle as the compare
	assign rd_en   = (state_q == S_PROBE) && go;
	assign rd_addr = base_q + AW'(nmid);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// search sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			pend_q  <= 1'b0;
			hash_q  <= '0;
			base_q  <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (launch) begin
						state_q <= S_PROBE;
						lo_q    <= '0;
						hi_q    <= launch_count;
						pend_q  <= 1'b0;
						hash_q  <= launch_hash;
						base_q  <= launch_base;
					end
				end
				S_PROBE: begin
					if (hit) begin
						state_q      <= S_IDLE;
						pend_q       <= 1'b0;
						done_q       <= 1'b1;
						res_q.found  <= 1'b1;
						res_q.offset <= rd_data[31:0];
						res_q.hash   <= hash_q;
					end else if (!go) begin
						state_q      <= S_IDLE;
						pend_q       <= 1'b0;
						done_q       <= 1'b1;
						res_q.found  <= 1'b0;
						res_q.offset <= '0;
						res_q.hash   <= hash_q;
					end else begin
						lo_q   <= nlo;
						hi_q   <= nhi;
						mid_q  <= nmid;
						pend_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HKTL_ASSERT_SAME(a_probe_in_window, clk, arst_n, rd_en, nmid < nhi, "probe outside window")
	`HKTL_ASSERT_NEXT(a_done_one_cycle, clk, arst_n, done_q, !done_q, "result strobe held")
	`HKTL_ASSERT_SAME(a_end_with_result, clk, arst_n, $fell(busy), done_q, "search ended silently")
	`HKTL_ASSERT_SAME(a_miss_zero_offset, clk, arst_n, done_q && !res_q.found, res_q.offset == '0, "miss with offset")

endmodule
